>>> sv/osk_pkg.sv
// ============================================================================
// osk_pkg
// Shared types and constants of the ordered string key encoder
// ============================================================================
package osk_pkg;

    // command codes of an input request
    localparam logic [1:0] CMD_DATA  = 2'd0;
    localparam logic [1:0] CMD_FINAL = 2'd1;
    localparam logic [1:0] CMD_EMPTY = 2'd2;
    localparam logic [1:0] CMD_NULL  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_TAGS_ON       = 2'd0;
    localparam logic [1:0] REG_APPEND_LENGTH = 2'd1;
    localparam logic [1:0] REG_NULL_TAG      = 2'd2;
    localparam logic [1:0] REG_NOT_NULL_TAG  = 2'd3;

    localparam int GROUP_BYTES = 8;
    localparam int TOTAL_W     = 28;
    localparam int SIZE_W      = 32;
    localparam logic [TOTAL_W-1:0] GROUP_MAX = {TOTAL_W{1'b1}};
    localparam logic [7:0] GROUP_MARK  = 8'hFF;
    localparam logic [7:0] TERM_BASE   = 8'd255;
    localparam logic [2:0] LEN_BYTES   = 3'd4;

    // queue between front and back
    localparam int JOB_DEPTH = 4;
    localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
    localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data_byte;
    } t_in_req;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_value;
        logic       bad_input;
    } t_out_rsp;

    typedef struct packed {
        logic       tags_on;
        logic       append_length;
        logic [7:0] null_tag;
        logic [7:0] not_null_tag;
    } t_cfg;

    // one classified request: the pieces the back end still has to emit
    typedef struct packed {
        logic              tag_en;
        logic              tag_bad;
        logic [7:0]        tag_byte;
        logic              byte_en;
        logic [7:0]        data_byte;
        logic              ff_en;
        logic              ff_bad;
        logic [3:0]        pad_cnt;
        logic              term_en;
        logic [7:0]        term_byte;
        logic [2:0]        len_cnt;
        logic [SIZE_W-1:0] size;
        logic              eov;
    } t_job;

endpackage

>>> sv/osk_front.sv
// ============================================================================
// osk_front
// Classifies each request against the value state and builds a job
// ============================================================================
module osk_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  osk_pkg::t_cfg   i_cfg,
    input  logic            i_take,
    input  osk_pkg::t_in_req i_req,
    output osk_pkg::t_job   o_job
);

    logic [2:0]                   r_group_fill;
    logic [osk_pkg::TOTAL_W-1:0]  r_group_total;
    logic                         r_value_open;

    logic [2:0]                   n_group_fill;
    logic [osk_pkg::TOTAL_W-1:0]  n_group_total;
    logic                         n_value_open;

    logic [3:0]                   fill_inc;
    logic [2:0]                   fill_after;
    logic [osk_pkg::TOTAL_W-1:0]  total_after;
    logic                         group_done;
    logic [3:0]                   pad;
    logic [osk_pkg::SIZE_W-1:0]   total_p1;
    logic [osk_pkg::SIZE_W-1:0]   size;
    logic                         has_byte;
    logic                         closes;

    always_comb begin
        has_byte   = i_req.command inside {osk_pkg::CMD_DATA, osk_pkg::CMD_FINAL};
        closes     = i_req.command inside {osk_pkg::CMD_FINAL, osk_pkg::CMD_EMPTY};

        fill_inc   = {1'b0, r_group_fill} + 4'd1;
        group_done = has_byte && fill_inc[3];
        if (!has_byte) begin
            fill_after = r_group_fill;
        end else if (group_done) begin
            fill_after = 3'd0;
        end else begin
            fill_after = fill_inc[2:0];
        end
        if (group_done && (r_group_total != osk_pkg::GROUP_MAX)) begin
            total_after = r_group_total + 1'b1;
        end else begin
            total_after = r_group_total;
        end

        pad      = 4'd8 - {1'b0, fill_after};
        total_p1 = {{(osk_pkg::SIZE_W - osk_pkg::TOTAL_W){1'b0}}, total_after} + 1'b1;
        // times nine as a shift and add
        size     = {total_p1[osk_pkg::SIZE_W-4:0], 3'b000} + total_p1;

        o_job = '0;
        n_group_fill  = r_group_fill;
        n_group_total = r_group_total;
        n_value_open  = r_value_open;

        if (i_req.command == osk_pkg::CMD_NULL) begin
            o_job.tag_en = 1'b1;
            o_job.eov    = 1'b1;
            if (r_value_open || !i_cfg.tags_on) begin
                // rejected null, open value abandoned
                o_job.tag_bad  = 1'b1;
                o_job.tag_byte = 8'd0;
                n_group_fill   = 3'd0;
                n_group_total  = '0;
                n_value_open   = 1'b0;
            end else begin
                o_job.tag_byte = i_cfg.null_tag;
                o_job.len_cnt  = i_cfg.append_length ? osk_pkg::LEN_BYTES : 3'd0;
                o_job.size     = '0;
            end
        end else begin
            o_job.tag_en    = !r_value_open && i_cfg.tags_on;
            o_job.tag_byte  = i_cfg.not_null_tag;
            o_job.byte_en   = has_byte;
            o_job.data_byte = i_req.data_byte;
            o_job.ff_en     = group_done;
            o_job.ff_bad    = r_group_total == osk_pkg::GROUP_MAX;
            n_group_fill    = fill_after;
            n_group_total   = total_after;
            n_value_open    = 1'b1;
            if (closes) begin
                o_job.pad_cnt   = pad;
                o_job.term_en   = 1'b1;
                o_job.term_byte = osk_pkg::TERM_BASE - {4'd0, pad};
                o_job.len_cnt   = i_cfg.append_length ? osk_pkg::LEN_BYTES : 3'd0;
                o_job.size      = size;
                o_job.eov       = 1'b1;
                n_group_fill    = 3'd0;
                n_group_total   = '0;
                n_value_open    = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_fill  <= 3'd0;
            r_group_total <= '0;
            r_value_open  <= 1'b0;
        end else if (i_take) begin
            r_group_fill  <= n_group_fill;
            r_group_total <= n_group_total;
            r_value_open  <= n_value_open;
        end
    end

endmodule

>>> sv/osk_fifo.sv
// ============================================================================
// osk_fifo
// Short job queue between the front and back ends
// ============================================================================
module osk_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  osk_pkg::t_job i_job,
    input  logic          i_pop,
    output osk_pkg::t_job o_head,
    output logic          o_full,
    output logic          o_empty
);

    osk_pkg::t_job                 r_mem [osk_pkg::JOB_DEPTH];
    logic [osk_pkg::JOB_PTR_W-1:0] r_wr_ptr;
    logic [osk_pkg::JOB_PTR_W-1:0] r_rd_ptr;
    logic [osk_pkg::JOB_CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = r_count == osk_pkg::JOB_CNT_W'(osk_pkg::JOB_DEPTH);
    assign o_empty = r_count == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> sv/osk_back.sv
// ============================================================================
// osk_back
// Emits queued jobs' bytes to an output register, one per cycle unless stalled
// ============================================================================
module osk_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  osk_pkg::t_job     i_head,
    input  logic              i_empty,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output osk_pkg::t_out_rsp o_rsp
);

    osk_pkg::t_job     r_job;
    logic              r_busy;
    osk_pkg::t_out_rsp r_out;
    logic              r_out_valid;

    osk_pkg::t_job     n_job;
    logic [7:0]        cur_byte;
    logic              cur_bad;
    logic              last;
    logic              out_free;
    logic              step;
    logic              load;

    always_comb begin
        n_job    = r_job;
        cur_byte = 8'd0;
        cur_bad  = 1'b0;
        // fixed order: tag, data, group mark, padding, terminator, size
        if (r_job.tag_en) begin
            cur_byte     = r_job.tag_byte;
            cur_bad      = r_job.tag_bad;
            n_job.tag_en = 1'b0;
        end else if (r_job.byte_en) begin
            cur_byte      = r_job.data_byte;
            n_job.byte_en = 1'b0;
        end else if (r_job.ff_en) begin
            cur_byte    = osk_pkg::GROUP_MARK;
            cur_bad     = r_job.ff_bad;
            n_job.ff_en = 1'b0;
        end else if (r_job.pad_cnt != 4'd0) begin
            cur_byte      = 8'd0;
            n_job.pad_cnt = r_job.pad_cnt - 4'd1;
        end else if (r_job.term_en) begin
            cur_byte      = r_job.term_byte;
            n_job.term_en = 1'b0;
        end else begin
            case (r_job.len_cnt)
                3'd4:    cur_byte = r_job.size[31:24];
                3'd3:    cur_byte = r_job.size[23:16];
                3'd2:    cur_byte = r_job.size[15:8];
                3'd1:    cur_byte = r_job.size[7:0];
                default: cur_byte = 8'd0;
            endcase
            if (r_job.len_cnt != 3'd0) begin
                n_job.len_cnt = r_job.len_cnt - 3'd1;
            end
        end
        last = !n_job.tag_en && !n_job.byte_en && !n_job.ff_en &&
               (n_job.pad_cnt == 4'd0) && !n_job.term_en && (n_job.len_cnt == 3'd0);

        out_free = !r_out_valid || i_ready;
        step     = r_busy && out_free;
        load     = (!r_busy || (step && last)) && !i_empty;
    end

    assign o_pop   = load;
    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= i_head;
        end else if (step) begin
            r_job <= n_job;
        end
        if (step) begin
            r_out.out_byte     <= cur_byte;
            r_out.bad_input    <= cur_bad;
            r_out.end_of_value <= last && r_job.eov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
            end else if (step && last) begin
                r_busy <= 1'b0;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

>>> sv/ordered_string_key_encoder_unit.sv
// ============================================================================
// ordered_string_key_encoder_unit
// Order-preserving byte-group encoder for string keys
// ============================================================================
// Requests carry the bytes of one string key (data, final data, empty value
// or null value) and each leaves as one or more encoded bytes on the output
// channel, one byte per cycle unless the output stalls: groups of eight with
// a 0xff mark, zero padding and a terminator at the end of the value, an
// optional null / not-null tag and, in full-key mode, the four-byte big-endian
// encoded size. A request is taken whenever the four-entry job queue has
// room; the output side then produces 1 to 15 bytes for it (two for a plain
// data byte that completes a group or opens a tagged value, one otherwise), so
// the output register's byte-per-cycle rate sets the sustained throughput.
// Configuration writes take effect at once and are meant for when the block
// is idle.
// ============================================================================
module ordered_string_key_encoder_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request channel
    input  logic              i_valid,
    output logic              o_ready,
    input  osk_pkg::t_in_req  i_req,
    // encoded byte channel
    output logic              o_valid,
    input  logic              i_ready,
    output osk_pkg::t_out_rsp o_rsp,
    // configuration writes
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [7:0]        i_cfg_data
);

    osk_pkg::t_cfg r_cfg;
    osk_pkg::t_job front_job;
    osk_pkg::t_job head_job;
    logic          q_full;
    logic          q_empty;
    logic          q_pop;
    logic          take;

    // a request is taken whenever the queue has a free slot
    assign o_ready = !q_full;
    assign take    = i_valid && !q_full;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tags_on       <= 1'b0;
            r_cfg.append_length <= 1'b1;
            r_cfg.null_tag      <= 8'd0;
            r_cfg.not_null_tag  <= 8'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                osk_pkg::REG_TAGS_ON:       r_cfg.tags_on       <= i_cfg_data[0];
                osk_pkg::REG_APPEND_LENGTH: r_cfg.append_length <= i_cfg_data[0];
                osk_pkg::REG_NULL_TAG:      r_cfg.null_tag      <= i_cfg_data;
                osk_pkg::REG_NOT_NULL_TAG:  r_cfg.not_null_tag  <= i_cfg_data;
                default:                    r_cfg.tags_on       <= r_cfg.tags_on;
            endcase
        end
    end

    // front end: tracks group fill / count and classifies the request
    osk_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_take  (take),
        .i_req   (i_req),
        .o_job   (front_job)
    );

    // job queue lets the front keep taking requests during output bursts
    osk_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take),
        .i_job   (front_job),
        .i_pop   (q_pop),
        .o_head  (head_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // back end: sequences each job's bytes into the output register
    osk_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head_job),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rsp   (o_rsp)
    );

endmodule
